[rtl/core/modular_square_root_prime_defines.svh]
// assertion helpers for the modular square root core
// the macros expect clk and rst_n in the scope where they are used
`ifndef MODULAR_SQUARE_ROOT_PRIME_DEFINES_SVH
`define MODULAR_SQUARE_ROOT_PRIME_DEFINES_SVH
`ifndef SYNTHESIS
`define MSRP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MSRP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MSRP_ASSERT(lbl, prop, msg)
`define MSRP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[rtl/core/msrp_pkg.sv]
// ----------------------------------------------------------------------------
// msrp_pkg
// shared widths and constants of the modular square root core
// ----------------------------------------------------------------------------
`default_nettype none

package msrp_pkg;
    localparam int WIDTH_DEF = 32;
    localparam int VALUE_W   = 33;
    localparam int MOD_W     = 32;
    localparam int ROOT_W    = 32;
    localparam int VCNT_W    = 6;
    localparam logic [63:0] ZSEARCH_LIMIT = 64'd65536;

    // result status codes
    localparam logic STATUS_ROOT   = 1'b0;
    localparam logic STATUS_NONRES = 1'b1;
endpackage

`default_nettype wire

[rtl/core/msrp_req_if.sv]
// ----------------------------------------------------------------------------
// msrp_req_if
// request channel: signed value and prime modulus
// ----------------------------------------------------------------------------
`default_nettype none

interface msrp_req_if
    import msrp_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic        [MOD_W-1:0]   modulus;

    modport source (output valid, output value, output modulus, input ready);
    modport sink   (input valid, input value, input modulus, output ready);
endinterface

`default_nettype wire

[rtl/core/msrp_rsp_if.sv]
// ----------------------------------------------------------------------------
// msrp_rsp_if
// response channel: root and residue status
// ----------------------------------------------------------------------------
`default_nettype none

interface msrp_rsp_if
    import msrp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ROOT_W-1:0] root;
    logic              status;

    modport source (output valid, output root, output status, input ready);
    modport sink   (input valid, input root, input status, output ready);
endinterface

`default_nettype wire

[rtl/core/modular_square_root_prime.sv]
// ----------------------------------------------------------------------------
// modular_square_root_prime
// Tonelli-Shanks square root modulo a prime, one shared modular adder
// ----------------------------------------------------------------------------
// One request at a time. The value is reduced bit by bit, then a sequencer
// drives a single modular adder: a modular multiply doubles, then
// conditionally adds, per bit of the multiplier, a modular power takes
// about 2*PW multiplies, and the Jacobi symbol does one shift, swap or
// subtract step per cycle. The Tonelli-Shanks path (p = 1 mod 4) also runs
// up to s*s squarings and a non-residue search, each a multiply or Jacobi
// run. The request side is ready only when idle; the result waits in an
// output register.
`default_nettype none

`include "modular_square_root_prime_defines.svh"

module modular_square_root_prime
    import msrp_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF
)(
    input  wire         clk,
    input  wire         rst_n,
    msrp_req_if.sink    req,
    msrp_rsp_if.source  rsp
);
    localparam int PW  = (WIDTH < MOD_W) ? WIDTH : MOD_W;
    localparam int CW  = $clog2(PW + 1);
    localparam int BW  = $clog2(PW);

    localparam logic [4:0] S_IDLE = 5'd0,  S_RED  = 5'd1,  S_FIX  = 5'd2,
                           S_DISP = 5'd3,  S_JAC  = 5'd4,  S_J34  = 5'd5,
                           S_POW  = 5'd6,  S_POW1 = 5'd7,  S_POW2 = 5'd8,
                           S_P34  = 5'd9,  S_QS   = 5'd10, S_K    = 5'd11,
                           S_N1   = 5'd12, S_N2   = 5'd13, S_N3   = 5'd14,
                           S_ZT   = 5'd15, S_ZJ   = 5'd16, S_C    = 5'd17,
                           S_LOOP = 5'd18, S_SQ   = 5'd19, S_SQ1  = 5'd20,
                           S_CI   = 5'd21, S_CI1  = 5'd22, S_R    = 5'd23,
                           S_CC   = 5'd24, S_NN   = 5'd25, S_MUL  = 5'd26,
                           S_DONE = 5'd27;

    logic [4:0]        state_reg, state_next;
    logic [4:0]        mret_reg, mret_next, pret_reg, pret_next, jret_reg, jret_next;
    logic [PW-1:0]     p_reg, p_next, a_reg, a_next, r_reg, r_next, n_reg, n_next;
    logic [PW-1:0]     c_reg, c_next, z_reg, z_next, q_reg, q_next, t_reg, t_next;
    logic [PW-1:0]     mx_reg, mx_next, my_reg, my_next, acc_reg, acc_next;
    logic [PW-1:0]     pres_reg, pres_next, pb_reg, pb_next, pe_reg, pe_next;
    logic [PW-1:0]     ja_reg, ja_next, jn_reg, jn_next;
    logic              jneg_reg, jneg_next, ph_reg, ph_next, neg_reg, neg_next;
    logic [CW-1:0]     s_reg, s_next, m_reg, m_next, i_reg, i_next;
    logic [BW-1:0]     cnt_reg, cnt_next;
    logic [VALUE_W-1:0] v_reg, v_next;
    logic [VCNT_W-1:0] vcnt_reg, vcnt_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic              status_reg, status_next;

    // shared modular adder
    logic [PW-1:0] ux, uy, usum;
    logic          ucin;
    logic [PW:0]   uraw;
    logic          jone;

    assign uraw = {1'b0, ux} + {1'b0, uy} + {{PW{1'b0}}, ucin};
    assign usum = (uraw >= {1'b0, p_reg}) ? PW'(uraw - {1'b0, p_reg}) : uraw[PW-1:0];
    assign jone = (jn_reg == PW'(1)) && !jneg_reg;

    assign req.ready  = (state_reg == S_IDLE);
    assign rsp.valid  = (state_reg == S_DONE);
    assign rsp.root   = root_reg;
    assign rsp.status = status_reg;

    always_comb
    begin
        ux = acc_reg;
        uy = acc_reg;
        ucin = 1'b0;
        case (state_reg)
            S_RED:
            begin
                ux = a_reg;
                uy = a_reg;
                ucin = v_reg[vcnt_reg];
            end
            S_MUL:
            begin
                if (ph_reg)
                begin
                    uy = mx_reg;
                end
            end
            default:
            begin
                ux = acc_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        mret_next = mret_reg;
        pret_next = pret_reg;
        jret_next = jret_reg;
        p_next = p_reg;
        a_next = a_reg;
        r_next = r_reg;
        n_next = n_reg;
        c_next = c_reg;
        z_next = z_reg;
        q_next = q_reg;
        t_next = t_reg;
        mx_next = mx_reg;
        my_next = my_reg;
        acc_next = acc_reg;
        pres_next = pres_reg;
        pb_next = pb_reg;
        pe_next = pe_reg;
        ja_next = ja_reg;
        jn_next = jn_reg;
        jneg_next = jneg_reg;
        ph_next = ph_reg;
        neg_next = neg_reg;
        s_next = s_reg;
        m_next = m_reg;
        i_next = i_reg;
        cnt_next = cnt_reg;
        v_next = v_reg;
        vcnt_next = vcnt_reg;
        root_next = root_reg;
        status_next = status_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    p_next = req.modulus[PW-1:0];
                    neg_next = req.value[VALUE_W-1];
                    v_next = req.value[VALUE_W-1] ? (~req.value + 1'b1) : req.value;
                    a_next = '0;
                    vcnt_next = VCNT_W'(VALUE_W - 1);
                    root_next = '0;
                    status_next = STATUS_ROOT;
                    if (req.modulus[PW-1:0] < PW'(2))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_RED;
                    end
                end
            end
            S_RED:
            begin
                a_next = usum;
                vcnt_next = vcnt_reg - 1'b1;
                if (vcnt_reg == '0)
                begin
                    state_next = S_FIX;
                end
            end
            S_FIX:
            begin
                if (neg_reg && (a_reg != '0))
                begin
                    a_next = p_reg - a_reg;
                end
                state_next = S_DISP;
            end
            S_DISP:
            begin
                if (a_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else if (p_reg == PW'(2))
                begin
                    root_next = ROOT_W'(a_reg);
                    state_next = S_DONE;
                end
                else if (!p_reg[0])
                begin
                    status_next = STATUS_NONRES;
                    state_next = S_DONE;
                end
                else if (p_reg[1])
                begin
                    ja_next = a_reg;
                    jn_next = p_reg;
                    jneg_next = 1'b0;
                    jret_next = S_J34;
                    state_next = S_JAC;
                end
                else
                begin
                    q_next = p_reg - 1'b1;
                    s_next = '0;
                    state_next = S_QS;
                end
            end
            // binary jacobi symbol, one step per cycle
            S_JAC:
            begin
                if (ja_reg == '0)
                begin
                    state_next = jret_reg;
                end
                else if (!ja_reg[0])
                begin
                    ja_next = ja_reg >> 1;
                    if (jn_reg[2:0] inside {3'd3, 3'd5})
                    begin
                        jneg_next = !jneg_reg;
                    end
                end
                else if (ja_reg < jn_reg)
                begin
                    ja_next = jn_reg;
                    jn_next = ja_reg;
                    if (ja_reg[1] && jn_reg[1])
                    begin
                        jneg_next = !jneg_reg;
                    end
                end
                else
                begin
                    ja_next = ja_reg - jn_reg;
                end
            end
            S_J34:
            begin
                if (jone)
                begin
                    pres_next = PW'(1);
                    pb_next = a_reg;
                    pe_next = (p_reg >> 2) + 1'b1;
                    pret_next = S_P34;
                    state_next = S_POW;
                end
                else
                begin
                    status_next = STATUS_NONRES;
                    state_next = S_DONE;
                end
            end
            S_POW:
            begin
                if (pe_reg == '0)
                begin
                    state_next = pret_reg;
                end
                else
                begin
                    mx_next = pe_reg[0] ? pres_reg : pb_reg;
                    my_next = pb_reg;
                    mret_next = pe_reg[0] ? S_POW1 : S_POW2;
                    acc_next = '0;
                    cnt_next = BW'(PW - 1);
                    ph_next = 1'b0;
                    state_next = S_MUL;
                end
            end
            S_POW1:
            begin
                pres_next = acc_reg;
                mx_next = pb_reg;
                my_next = pb_reg;
                mret_next = S_POW2;
                acc_next = '0;
                cnt_next = BW'(PW - 1);
                ph_next = 1'b0;
                state_next = S_MUL;
            end
            S_POW2:
            begin
                pb_next = acc_reg;
                pe_next = pe_reg >> 1;
                state_next = S_POW;
            end
            S_P34:
            begin
                root_next = ROOT_W'(pres_reg);
                state_next = S_DONE;
            end
            S_QS:
            begin
                if (!q_reg[0])
                begin
                    q_next = q_reg >> 1;
                    s_next = s_reg + 1'b1;
                end
                else
                begin
                    pres_next = PW'(1);
                    pb_next = a_reg;
                    pe_next = (q_reg - 1'b1) >> 1;
                    pret_next = S_K;
                    state_next = S_POW;
                end
            end
            S_K:
            begin
                r_next = pres_reg;
                mx_next = pres_reg;
                my_next = pres_reg;
                mret_next = S_N1;
                acc_next = '0;
                cnt_next = BW'(PW - 1);
                ph_next = 1'b0;
                state_next = S_MUL;
            end
            S_N1:
            begin
                mx_next = acc_reg;
                my_next = a_reg;
                mret_next = S_N2;
                acc_next = '0;
                cnt_next = BW'(PW - 1);
                ph_next = 1'b0;
                state_next = S_MUL;
            end
            S_N2:
            begin
                n_next = acc_reg;
                mx_next = r_reg;
                my_next = a_reg;
                mret_next = S_N3;
                acc_next = '0;
                cnt_next = BW'(PW - 1);
                ph_next = 1'b0;
                state_next = S_MUL;
            end
            S_N3:
            begin
                r_next = acc_reg;
                if (n_reg == PW'(1))
                begin
                    root_next = ROOT_W'(acc_reg);
                    state_next = S_DONE;
                end
                else
                begin
                    z_next = PW'(2);
                    state_next = S_ZT;
                end
            end
            // non-residue search
            S_ZT:
            begin
                if ((z_reg >= p_reg) || (64'(z_reg) >= ZSEARCH_LIMIT))
                begin
                    status_next = STATUS_NONRES;
                    state_next = S_DONE;
                end
                else
                begin
                    ja_next = z_reg;
                    jn_next = p_reg;
                    jneg_next = 1'b0;
                    jret_next = S_ZJ;
                    state_next = S_JAC;
                end
            end
            S_ZJ:
            begin
                if (jone)
                begin
                    z_next = z_reg + 1'b1;
                    state_next = S_ZT;
                end
                else
                begin
                    pres_next = PW'(1);
                    pb_next = z_reg;
                    pe_next = q_reg;
                    pret_next = S_C;
                    state_next = S_POW;
                end
            end
            S_C:
            begin
                c_next = pres_reg;
                state_next = S_LOOP;
            end
            S_LOOP:
            begin
                if (n_reg > PW'(1))
                begin
                    t_next = n_reg;
                    m_next = '0;
                    state_next = S_SQ;
                end
                else
                begin
                    root_next = ROOT_W'(r_reg);
                    state_next = S_DONE;
                end
            end
            S_SQ:
            begin
                if ((t_reg != PW'(1)) && (m_reg < s_reg))
                begin
                    mx_next = t_reg;
                    my_next = t_reg;
                    mret_next = S_SQ1;
                    acc_next = '0;
                    cnt_next = BW'(PW - 1);
                    ph_next = 1'b0;
                    state_next = S_MUL;
                end
                else if ((t_reg != PW'(1)) || (m_reg >= s_reg))
                begin
                    status_next = STATUS_NONRES;
                    state_next = S_DONE;
                end
                else
                begin
                    i_next = s_reg - m_reg - 1'b1;
                    state_next = S_CI;
                end
            end
            S_SQ1:
            begin
                t_next = acc_reg;
                m_next = m_reg + 1'b1;
                state_next = S_SQ;
            end
            S_CI:
            begin
                mx_next = (i_reg != '0) ? c_reg : r_reg;
                my_next = c_reg;
                mret_next = (i_reg != '0) ? S_CI1 : S_R;
                acc_next = '0;
                cnt_next = BW'(PW - 1);
                ph_next = 1'b0;
                state_next = S_MUL;
            end
            S_CI1:
            begin
                c_next = acc_reg;
                i_next = i_reg - 1'b1;
                state_next = S_CI;
            end
            S_R:
            begin
                r_next = acc_reg;
                mx_next = c_reg;
                my_next = c_reg;
                mret_next = S_CC;
                acc_next = '0;
                cnt_next = BW'(PW - 1);
                ph_next = 1'b0;
                state_next = S_MUL;
            end
            S_CC:
            begin
                c_next = acc_reg;
                mx_next = n_reg;
                my_next = acc_reg;
                mret_next = S_NN;
                acc_next = '0;
                cnt_next = BW'(PW - 1);
                ph_next = 1'b0;
                state_next = S_MUL;
            end
            S_NN:
            begin
                n_next = acc_reg;
                s_next = m_reg;
                state_next = S_LOOP;
            end
            // shift-and-add multiply, msb first: double, then add if bit set
            S_MUL:
            begin
                ph_next = !ph_reg;
                if (!ph_reg)
                begin
                    acc_next = usum;
                end
                else
                begin
                    if (my_reg[cnt_reg])
                    begin
                        acc_next = usum;
                    end
                    if (cnt_reg == '0)
                    begin
                        state_next = mret_reg;
                    end
                    else
                    begin
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
            end
            S_DONE:
            begin
                if (rsp.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mret_reg <= mret_next;
        pret_reg <= pret_next;
        jret_reg <= jret_next;
        p_reg <= p_next;
        a_reg <= a_next;
        r_reg <= r_next;
        n_reg <= n_next;
        c_reg <= c_next;
        z_reg <= z_next;
        q_reg <= q_next;
        t_reg <= t_next;
        mx_reg <= mx_next;
        my_reg <= my_next;
        acc_reg <= acc_next;
        pres_reg <= pres_next;
        pb_reg <= pb_next;
        pe_reg <= pe_next;
        ja_reg <= ja_next;
        jn_reg <= jn_next;
        jneg_reg <= jneg_next;
        ph_reg <= ph_next;
        neg_reg <= neg_next;
        s_reg <= s_next;
        m_reg <= m_next;
        i_reg <= i_next;
        cnt_reg <= cnt_next;
        v_reg <= v_next;
        vcnt_reg <= vcnt_next;
        root_reg <= root_next;
        status_reg <= status_next;
    end

    `MSRP_ASSERT(a_nonres_zero, (rsp.valid && (status_reg == STATUS_NONRES)) |-> (root_reg == '0), "non-residue with nonzero root")
    `MSRP_ASSERT(a_root_range, (rsp.valid && (p_reg >= PW'(2))) |-> (root_reg < ROOT_W'(p_reg)), "root not below modulus")
    `MSRP_ASSERT(a_jac_odd, (state_reg == S_JAC) |-> jn_reg[0], "jacobi modulus became even")
    `MSRP_ASSERT(a_mul_acc, (state_reg == S_MUL) |-> (acc_reg < p_reg), "multiply accumulator not reduced")
    `MSRP_ASSERT_NEXT(a_start, (req.valid && req.ready && (req.modulus[PW-1:0] >= PW'(2))), (state_reg == S_RED), "transfer did not start reduction")

endmodule

`default_nettype wire
